>>> src/rst_pkg.sv
`default_nettype none
package rst_pkg;

  // Datapath sizing
  localparam int CORDIC_STEPS  = 16;
  localparam int FRACTION_BITS = 16;
  localparam int GUARD_BITS    = 8;
  localparam int ATAN_LEN      = 24;
  localparam int NUM_STEPS     = (CORDIC_STEPS > ATAN_LEN) ? ATAN_LEN : CORDIC_STEPS;
  localparam int STEP_W        = $clog2(ATAN_LEN);

  // Field widths
  localparam int COORD_W    = 18;
  localparam int CFG_W      = 14;
  localparam int FRAC_OUT_W = 16;
  localparam int RADIUS_W   = 18;

  // Centred coordinate, CORDIC vector and angle widths
  localparam int U_W      = ((FRACTION_BITS > COORD_W - 1) ? FRACTION_BITS : COORD_W - 1) + 2;
  localparam int X_W      = U_W + GUARD_BITS + 2;
  localparam int XC_W     = X_W - 1;
  localparam int Z_W      = 32;
  localparam int ANGLE_FB = 32;
  localparam int NORM_W   = ANGLE_FB + 1;
  localparam int SIDES_FB = 8;

  // Stream packing
  localparam int IN_TDATA_W  = ((2 * COORD_W + 7) / 8) * 8;
  localparam int OUT_TDATA_W = ((FRAC_OUT_W + RADIUS_W + 7) / 8) * 8;
  localparam int IN_PAD_W    = IN_TDATA_W - 2 * COORD_W;
  localparam int OUT_PAD_W   = OUT_TDATA_W - FRAC_OUT_W - RADIUS_W;

  // Constants
  localparam logic [31:0]         INV_GAIN   = 32'd2608131496;
  localparam logic [RADIUS_W-1:0] RADIUS_MAX = '1;
  localparam logic [CFG_W-1:0]    SIDES_ONE  = CFG_W'(1) << SIDES_FB;
  localparam logic [CFG_W-1:0]    CFG_RESET  = CFG_W'(1280);
  localparam int                  SECTOR_LSB = ANGLE_FB + SIDES_FB - FRAC_OUT_W;

  typedef struct packed {
    logic signed [X_W-1:0] x;
    logic signed [X_W-1:0] y;
    logic signed [Z_W-1:0] z;
    logic                  flipped;   // centred x was negative, vector negated
    logic                  v_pos;     // centred y strictly positive
    logic                  on_axis;   // centred y exactly zero
    logic [U_W-1:0]        mag;       // |centred x|, radius on the axis
  } cordic_t;

  // arctan(2^-i) in turns, 32 fraction bits
  function automatic logic signed [Z_W-1:0] atan_turns(input logic [STEP_W-1:0] idx);
    logic signed [Z_W-1:0] r;
    case (idx)
      5'd0:    r = 32'sd536870912;
      5'd1:    r = 32'sd316933406;
      5'd2:    r = 32'sd167458907;
      5'd3:    r = 32'sd85004756;
      5'd4:    r = 32'sd42667331;
      5'd5:    r = 32'sd21354465;
      5'd6:    r = 32'sd10679838;
      5'd7:    r = 32'sd5340245;
      5'd8:    r = 32'sd2670163;
      5'd9:    r = 32'sd1335087;
      5'd10:   r = 32'sd667544;
      5'd11:   r = 32'sd333772;
      5'd12:   r = 32'sd166886;
      5'd13:   r = 32'sd83443;
      5'd14:   r = 32'sd41722;
      5'd15:   r = 32'sd20861;
      5'd16:   r = 32'sd10430;
      5'd17:   r = 32'sd5215;
      5'd18:   r = 32'sd2608;
      5'd19:   r = 32'sd1304;
      5'd20:   r = 32'sd652;
      5'd21:   r = 32'sd326;
      5'd22:   r = 32'sd163;
      5'd23:   r = 32'sd81;
      default: r = '0;
    endcase
    return r;
  endfunction

endpackage
`default_nettype wire

>>> src/radial_sector_tiling.sv
// Radial sector tiling: each item carries a texture coordinate pair (x, y),
// signed with 16 fraction bits. The pair is centred on (0.5, 0.5), turned into
// polar form by a row of CORDIC vectoring cells (one rotation per cell, 16
// cells), and the angle, taken as a fraction of a turn offset by one half, is
// multiplied by side_count (8 fraction bits, values below 1.0 act as 1.0). The
// result item gives the fractional part of that product and the radius, rounded
// and saturated to 18 bits. The centre point gives a sector product of 0.5 times
// side_count. Throughput is one item per clock while the output is not held. The
// stages are one centring stage, one per CORDIC cell and two in the output unit,
// whose two multipliers set the longest path. Every stage has its own valid bit
// and takes a new item whenever it is empty or its successor moves, so bubbles
// close up, and while a finished result waits the input flows until all stages fill.
// side_count may only be written while no item is in flight.
`default_nettype none
module radial_sector_tiling (
  input  wire logic                            clk_i,
  input  wire logic                            rst_ni,
  // configuration
  input  wire logic                            cfg_we_i,
  input  wire logic [rst_pkg::CFG_W-1:0]       cfg_wdata_i,   // side_count
  // coordinate items
  input  wire logic                            s_axis_tvalid,
  output logic                                 s_axis_tready,
  input  wire logic [rst_pkg::IN_TDATA_W-1:0]  s_axis_tdata,  // coord_x, coord_y, pad
  // result items
  output logic                                 m_axis_tvalid,
  input  wire logic                            m_axis_tready,
  output logic [rst_pkg::OUT_TDATA_W-1:0]      m_axis_tdata   // sector_fraction, radius, pad
);
  import rst_pkg::*;

  logic [CFG_W-1:0] side_count_q;
  logic [CFG_W-1:0] sides;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      side_count_q <= CFG_RESET;
    end else if (cfg_we_i) begin
      side_count_q <= cfg_wdata_i;
    end
  end

  assign sides = (side_count_q < SIDES_ONE) ? SIDES_ONE : side_count_q;

  // link k feeds cell k; the last link feeds the output unit
  logic [NUM_STEPS:0] link_vld;
  logic [NUM_STEPS:0] link_rdy;
  cordic_t            link_data [NUM_STEPS+1];

  logic signed [COORD_W-1:0] coord_x, coord_y;
  logic [FRAC_OUT_W-1:0]     sector_fraction;
  logic [RADIUS_W-1:0]       radius;

  assign coord_x = s_axis_tdata[COORD_W-1:0];
  assign coord_y = s_axis_tdata[2*COORD_W-1:COORD_W];

  rst_prep u_prep (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_valid_i  (s_axis_tvalid),
    .in_ready_o  (s_axis_tready),
    .coord_x_i   (coord_x),
    .coord_y_i   (coord_y),
    .out_valid_o (link_vld[0]),
    .out_ready_i (link_rdy[0]),
    .out_data_o  (link_data[0])
  );

  for (genvar g = 0; g < NUM_STEPS; g++) begin : g_cell
    rst_cell u_cell (
      .clk_i       (clk_i),
      .rst_ni      (rst_ni),
      .step_i      (STEP_W'(g)),
      .in_valid_i  (link_vld[g]),
      .in_ready_o  (link_rdy[g]),
      .in_data_i   (link_data[g]),
      .out_valid_o (link_vld[g+1]),
      .out_ready_i (link_rdy[g+1]),
      .out_data_o  (link_data[g+1])
    );
  end

  rst_post u_post (
    .clk_i             (clk_i),
    .rst_ni            (rst_ni),
    .in_valid_i        (link_vld[NUM_STEPS]),
    .in_ready_o        (link_rdy[NUM_STEPS]),
    .in_data_i         (link_data[NUM_STEPS]),
    .sides_i           (sides),
    .out_valid_o       (m_axis_tvalid),
    .out_ready_i       (m_axis_tready),
    .sector_fraction_o (sector_fraction),
    .radius_o          (radius)
  );

  assign m_axis_tdata = {{OUT_PAD_W{1'b0}}, radius, sector_fraction};

  // input only stalls when every stage is full and the output is held
  a_stall_means_full: assert property (@(posedge clk_i) disable iff (!rst_ni)
    !s_axis_tready |-> (m_axis_tvalid && !m_axis_tready))
    else $error("input stalled with room in the pipeline");

  // first stage only fills from an accepted item
  a_fill_from_input: assert property (@(posedge clk_i) disable iff (!rst_ni)
    $rose(link_vld[0]) |-> $past(s_axis_tvalid && s_axis_tready))
    else $error("first stage filled without an accepted item");

  // the last cell never drops an item the output unit has not taken
  a_no_drop: assert property (@(posedge clk_i) disable iff (!rst_ni)
    $fell(link_vld[NUM_STEPS]) |-> $past(link_rdy[NUM_STEPS]))
    else $error("item lost between CORDIC row and output unit");

endmodule
`default_nettype wire

>>> src/rst_prep.sv
`default_nettype none
module rst_prep (
  input  wire logic                               clk_i,
  input  wire logic                               rst_ni,
  input  wire logic                               in_valid_i,
  output logic                                    in_ready_o,
  input  wire logic signed [rst_pkg::COORD_W-1:0] coord_x_i,
  input  wire logic signed [rst_pkg::COORD_W-1:0] coord_y_i,
  output logic                                    out_valid_o,
  input  wire logic                               out_ready_i,
  output rst_pkg::cordic_t                        out_data_o
);
  import rst_pkg::*;

  localparam logic signed [U_W-1:0] HALF = U_W'(1) << (FRACTION_BITS - 1);

  logic signed [U_W-1:0] u, v, xs, ys;
  cordic_t data_d, data_q;
  logic    valid_q;

  // centre on (0.5,0.5), fold the left half plane onto the right
  always_comb begin
    u = U_W'(coord_x_i) - HALF;
    v = U_W'(coord_y_i) - HALF;
    xs = u[U_W-1] ? -u : u;
    ys = u[U_W-1] ? -v : v;
    data_d.x       = X_W'(xs) <<< GUARD_BITS;
    data_d.y       = X_W'(ys) <<< GUARD_BITS;
    data_d.z       = '0;
    data_d.flipped = u[U_W-1];
    data_d.v_pos   = !v[U_W-1] && (v != '0);
    data_d.on_axis = (v == '0);
    data_d.mag     = xs;
  end

  assign in_ready_o  = !valid_q || out_ready_i;
  assign out_valid_o = valid_q;
  assign out_data_o  = data_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= 1'b0;
    end else if (in_ready_o) begin
      valid_q <= in_valid_i;
    end
  end

  always_ff @(posedge clk_i) begin
    if (in_ready_o && in_valid_i) begin
      data_q <= data_d;
    end
  end

endmodule
`default_nettype wire

>>> src/rst_cell.sv
`default_nettype none
module rst_cell (
  input  wire logic                      clk_i,
  input  wire logic                      rst_ni,
  input  wire logic [rst_pkg::STEP_W-1:0] step_i,
  input  wire logic                      in_valid_i,
  output logic                           in_ready_o,
  input  wire rst_pkg::cordic_t          in_data_i,
  output logic                           out_valid_o,
  input  wire logic                      out_ready_i,
  output rst_pkg::cordic_t               out_data_o
);
  import rst_pkg::*;

  logic signed [X_W-1:0] dx, dy;
  logic signed [Z_W-1:0] da;
  cordic_t data_d, data_q;
  logic    valid_q;

  // one vectoring rotation; step_i is tied off so the shifts fold to wiring
  always_comb begin
    dx = in_data_i.y >>> step_i;
    dy = in_data_i.x >>> step_i;
    da = atan_turns(step_i);
    data_d = in_data_i;
    if (in_data_i.y > 0) begin
      data_d.x = in_data_i.x + dx;
      data_d.y = in_data_i.y - dy;
      data_d.z = in_data_i.z + da;
    end else begin
      data_d.x = in_data_i.x - dx;
      data_d.y = in_data_i.y + dy;
      data_d.z = in_data_i.z - da;
    end
  end

  assign in_ready_o  = !valid_q || out_ready_i;
  assign out_valid_o = valid_q;
  assign out_data_o  = data_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= 1'b0;
    end else if (in_ready_o) begin
      valid_q <= in_valid_i;
    end
  end

  always_ff @(posedge clk_i) begin
    if (in_ready_o && in_valid_i) begin
      data_q <= data_d;
    end
  end

endmodule
`default_nettype wire

>>> src/rst_post.sv
`default_nettype none
module rst_post (
  input  wire logic                          clk_i,
  input  wire logic                          rst_ni,
  input  wire logic                          in_valid_i,
  output logic                               in_ready_o,
  input  wire rst_pkg::cordic_t              in_data_i,
  input  wire logic [rst_pkg::CFG_W-1:0]     sides_i,
  output logic                               out_valid_o,
  input  wire logic                          out_ready_i,
  output logic [rst_pkg::FRAC_OUT_W-1:0]     sector_fraction_o,
  output logic [rst_pkg::RADIUS_W-1:0]       radius_o
);
  import rst_pkg::*;

  localparam int N_W = Z_W + 3;
  localparam logic signed [N_W-1:0] TURN_HALF = N_W'(1) << (ANGLE_FB - 1);
  localparam logic signed [N_W-1:0] TURN_FULL = N_W'(1) << ANGLE_FB;
  localparam logic signed [Z_W-1:0] Z_ONE     = Z_W'(1);
  localparam int P_W = XC_W + 32;
  localparam logic [P_W-1:0] ROUND = P_W'(1) << (31 + GUARD_BITS);

  // stage A: angle normalisation and x clamp
  logic signed [Z_W-1:0]  zc;
  logic signed [N_W-1:0]  n;
  logic [NORM_W-1:0]      norm_d;
  logic [XC_W-1:0]        mag_d;
  logic                   a_vld_q, a_axis_q, a_ready;
  logic [NORM_W-1:0]      a_norm_q;
  logic [XC_W-1:0]        a_mag_q;

  always_comb begin
    zc = in_data_i.z;
    n  = '0;
    if (!in_data_i.flipped) begin
      n = TURN_HALF + N_W'(zc);
    end else if (in_data_i.v_pos) begin
      if (zc > -Z_ONE) zc = -Z_ONE;
      n = TURN_FULL + N_W'(zc);
    end else begin
      if (zc < Z_ONE) zc = Z_ONE;
      n = N_W'(zc);
    end
    if (n < 0) n = '0;
    if (n > TURN_FULL) n = TURN_FULL;
    if (in_data_i.on_axis) begin
      norm_d = in_data_i.flipped ? NORM_W'(TURN_FULL) : NORM_W'(TURN_HALF);
      mag_d  = XC_W'(in_data_i.mag);
    end else begin
      norm_d = NORM_W'(n);
      mag_d  = in_data_i.x[X_W-1] ? '0 : in_data_i.x[XC_W-1:0];
    end
  end

  // stage B: gain removal and sector product
  logic [P_W-1:0]             gain_prod;
  logic [XC_W-1:0]            rad_full;
  logic [NORM_W+CFG_W-1:0]    sect_prod;
  logic [RADIUS_W-1:0]        radius_d;
  logic                       b_vld_q;
  logic [FRAC_OUT_W-1:0]      sector_q;
  logic [RADIUS_W-1:0]        radius_q;

  always_comb begin
    gain_prod = P_W'(a_mag_q) * P_W'(INV_GAIN) + ROUND;
    rad_full  = a_axis_q ? a_mag_q : XC_W'(gain_prod >> (32 + GUARD_BITS));
    radius_d  = (rad_full > XC_W'(RADIUS_MAX)) ? RADIUS_MAX : rad_full[RADIUS_W-1:0];
    sect_prod = (NORM_W + CFG_W)'(a_norm_q) * (NORM_W + CFG_W)'(sides_i);
  end

  assign a_ready           = !b_vld_q || out_ready_i;
  assign in_ready_o        = !a_vld_q || a_ready;
  assign out_valid_o       = b_vld_q;
  assign sector_fraction_o = sector_q;
  assign radius_o          = radius_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      a_vld_q <= 1'b0;
      b_vld_q <= 1'b0;
    end else begin
      if (in_ready_o) a_vld_q <= in_valid_i;
      if (a_ready)    b_vld_q <= a_vld_q;
    end
  end

  always_ff @(posedge clk_i) begin
    if (in_ready_o && in_valid_i) begin
      a_norm_q <= norm_d;
      a_mag_q  <= mag_d;
      a_axis_q <= in_data_i.on_axis;
    end
    if (a_ready && a_vld_q) begin
      sector_q <= sect_prod[SECTOR_LSB +: FRAC_OUT_W];
      radius_q <= radius_d;
    end
  end

endmodule
`default_nettype wire
